/* hdl/avs_pkg.sv */
package avs_pkg;

  localparam int VALUE_W       = 32;
  localparam int MAX_ITEMS_DEF = 32;

  typedef logic signed [VALUE_W-1:0] value_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_mode_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } avs_state_t;

  // what one cell shows to its neighbors
  typedef struct packed {
    value_t value;
    logic   valid;
    logic   gt;
  } cell_link_t;

endpackage

/* hdl/avs_in_if.sv */
interface avs_in_if;
  import avs_pkg::*;

  logic   valid;
  logic   ready;
  value_t sample_value;
  logic   last_value;

  modport source (output valid, output sample_value, output last_value, input ready);
  modport sink   (input valid, input sample_value, input last_value, output ready);
endinterface

/* hdl/avs_out_if.sv */
interface avs_out_if;
  import avs_pkg::*;

  logic   valid;
  logic   ready;
  value_t sorted_value;
  logic   last_sorted;
  logic   overflow_seen;

  modport source (output valid, output sorted_value, output last_sorted,
                  output overflow_seen, input ready);
  modport sink   (input valid, input sorted_value, input last_sorted,
                  input overflow_seen, output ready);
endinterface

/* hdl/ascending_value_sorter.sv */
// Stable ascending sorter built as an insertion chain of MAX_ITEMS cells. While a set is
// collected one value is taken every cycle and dropped straight into its sorted place; the
// value marked last closes the set, and from the next cycle the set leaves smallest first,
// one result per cycle from the head cell while the consumer is ready. No input is taken
// during that drain. Values beyond MAX_ITEMS are dropped and every result of that set then
// carries overflow_seen.
module ascending_value_sorter #(
  parameter int MAX_ITEMS = avs_pkg::MAX_ITEMS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  avs_in_if.sink   in_ch,
  avs_out_if.source out_ch
);
  import avs_pkg::*;

  avs_state_t state_r, state_nxt;
  logic       overflow_r, overflow_nxt;
  cell_mode_t mode;
  cell_link_t links [MAX_ITEMS];
  cell_link_t edge_link;
  logic       in_xfer, out_xfer, full;

  assign edge_link = '{value: '0, valid: 1'b0, gt: 1'b0};
  assign full      = links[MAX_ITEMS-1].valid;
  assign in_xfer   = in_ch.valid && in_ch.ready;
  assign out_xfer  = out_ch.valid && out_ch.ready;

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    cell_link_t left_l, right_l;
    if (i == 0) begin : g_head
      assign left_l = edge_link;
    end else begin : g_mid
      assign left_l = links[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_l = edge_link;
    end else begin : g_body
      assign right_l = links[i+1];
    end
    avs_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .mode       (mode),
      .sample     (in_ch.sample_value),
      .left_link  (left_l),
      .right_link (right_l),
      .link       (links[i])
    );
  end

  // next state
  always_comb begin
    state_nxt    = state_r;
    overflow_nxt = overflow_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (in_xfer) begin
          if (full) overflow_nxt = 1'b1;
          if (in_ch.last_value) state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_xfer && out_ch.last_sorted) begin
          state_nxt    = ST_COLLECT;
          overflow_nxt = 1'b0;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready          = 1'b0;
    out_ch.valid         = 1'b0;
    mode                 = CELL_HOLD;
    unique case (state_r)
      ST_COLLECT: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid && !full) mode = CELL_INSERT;
      end
      ST_DRAIN: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) mode = CELL_SHIFT;
      end
      default: ;
    endcase
  end

  assign out_ch.sorted_value  = links[0].value;
  assign out_ch.last_sorted   = !links[1].valid;
  assign out_ch.overflow_seen = overflow_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_COLLECT;
      overflow_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      overflow_r <= overflow_nxt;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid))
    else $error("input and output open at once");

  a_head_filled: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> links[0].valid)
    else $error("result offered from an empty head cell");

  a_back_to_collect: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_ch.last_sorted) |=> (in_ch.ready && !overflow_r && !links[0].valid))
    else $error("set did not close cleanly");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.last_value) |=> out_ch.valid)
    else $error("no drain after last value");

endmodule

/* hdl/avs_cell.sv */
module avs_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  avs_pkg::cell_mode_t mode,
  input  avs_pkg::value_t     sample,
  input  avs_pkg::cell_link_t left_link,
  input  avs_pkg::cell_link_t right_link,
  output avs_pkg::cell_link_t link
);
  import avs_pkg::*;

  value_t value_r, value_nxt;
  logic   valid_r, valid_nxt;
  logic   gt;

  // empty cells count as larger than anything; strict compare keeps ties in arrival order
  assign gt = !valid_r || (value_r > sample);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    unique case (mode)
      CELL_HOLD: ;
      CELL_INSERT: begin
        if (gt) begin
          if (left_link.gt) begin
            value_nxt = left_link.value;
            valid_nxt = left_link.valid;
          end else begin
            value_nxt = sample;
            valid_nxt = 1'b1;
          end
        end
      end
      CELL_SHIFT: begin
        value_nxt = right_link.value;
        valid_nxt = right_link.valid;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign link.value = value_r;
  assign link.valid = valid_r;
  assign link.gt    = gt;

endmodule

/* dv/tb_ascending_value_sorter.sv */
module tb_ascending_value_sorter;
  timeunit 1ns;
  timeprecision 1ps;

  import avs_pkg::*;

  localparam int STORE_DEPTH  = MAX_ITEMS_DEF;
  localparam int RANDOM_ITEMS = 330;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_GUARD  = 3 * STORE_DEPTH;
  localparam int LONG_HOLD    = 150;

  typedef struct {
    value_t value;
    logic   last;
    logic   ovf;
  } sorted_item_t;

  // keeps the set being collected and the sorted results still owed by the block
  class sort_scoreboard;
    value_t       held_q[$];
    bit           dropped;
    sorted_item_t owed_q[$];
    int           capacity;
    int           errors;

    function new(int cap);
      capacity = cap;
      dropped  = 1'b0;
      errors   = 0;
    endfunction

    function void note_input(value_t v, logic last);
      value_t       swap;
      sorted_item_t item;
      int           n;
      if (held_q.size() < capacity) held_q.push_back(v);
      else dropped = 1'b1;
      if (!last) return;
      n = held_q.size();
      // stable: swap only on strictly greater, so equal values keep arrival order
      for (int i = 0; i + 1 < n; i++) begin
        for (int j = 0; j + 1 < n - i; j++) begin
          if (held_q[j] > held_q[j+1]) begin
            swap        = held_q[j];
            held_q[j]   = held_q[j+1];
            held_q[j+1] = swap;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        item.value = held_q[k];
        item.last  = (k == n - 1);
        item.ovf   = dropped;
        owed_q.push_back(item);
      end
      held_q.delete();
      dropped = 1'b0;
    endfunction

    function void check_result(value_t v, logic last, logic ovf);
      sorted_item_t exp_item;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result transfer: expected none, got value %0d last %0b ovf %0b",
                 $time, v, last, ovf);
        errors++;
        return;
      end
      exp_item = owed_q.pop_front();
      if (v !== exp_item.value) begin
        $display("%0t: sorted_value mismatch: expected %0d, got %0d",
                 $time, exp_item.value, v);
        errors++;
      end
      if (last !== exp_item.last) begin
        $display("%0t: last_sorted mismatch: expected %0b, got %0b",
                 $time, exp_item.last, last);
        errors++;
      end
      if (ovf !== exp_item.ovf) begin
        $display("%0t: overflow_seen mismatch: expected %0b, got %0b",
                 $time, exp_item.ovf, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;

  avs_in_if  in_ch();
  avs_out_if out_ch();

  ascending_value_sorter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sort_scoreboard sb = new(STORE_DEPTH);

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;
  int holds_done;
  int hold_left;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitors
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.sample_value, in_ch.last_value);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.sorted_value, out_ch.last_sorted, out_ch.overflow_seen);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("** ascending_value_sorter: FAILED **");
    $finish;
  end

  // result side: random stalls plus the long hold requested by the sender
  initial begin
    out_ch.ready = 1'b0;
    holds_done   = 0;
    hold_left    = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (holds_done != hold_requests) begin
        holds_done++;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
      @(posedge clk);
    end
  end

  task automatic send_value(value_t v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_value <= v;
    in_ch.last_value   <= last;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_list(value_t vals[$]);
    foreach (vals[k]) send_value(vals[k], k == vals.size() - 1);
  endtask

  function automatic value_t pick_value();
    value_t result;
    case ($urandom_range(3))
      0: result = value_t'($urandom);
      1: result = value_t'(int'($urandom_range(16)) - 8);
      2: begin
        case ($urandom_range(4))
          0: result = value_t'(32'h8000_0000);
          1: result = value_t'(32'h7FFF_FFFF);
          2: result = value_t'(32'hFFFF_FFFF);
          3: result = value_t'(32'h0000_0001);
          default: result = '0;
        endcase
      end
      // Q16.16 values in [-256, 256)
      default: result = value_t'((int'($urandom_range(511)) - 256) * 65536
                                 + int'($urandom_range(65535)));
    endcase
    return result;
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(99);
    if (r < 55) return $urandom_range(6, 1);
    if (r < 80) return $urandom_range(31, 7);
    if (r < 92) return $urandom_range(STORE_DEPTH + 1, STORE_DEPTH);
    return $urandom_range(STORE_DEPTH + 8, STORE_DEPTH + 2);
  endfunction

  task automatic send_set(int len, bit hold_on_last);
    for (int k = 0; k < len; k++) begin
      if (hold_on_last && k == len - 1) hold_requests++;
      send_value(pick_value(), k == len - 1);
    end
  endtask

  initial begin
    value_t list_q[$];
    int     sent;
    int     phase_goal;
    int     len;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.sample_value = '0;
    in_ch.last_value   = 1'b0;
    hold_requests      = 0;
    quiet_cycles       = 0;
    send_idle_pct      = 16;
    recv_idle_pct      = 78;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // single-value set at the top of the range
    list_q = '{value_t'(32'h7FFF_FFFF)};
    send_list(list_q);
    // extremes and signs
    list_q = '{value_t'(32'h8000_0000), value_t'(32'h7FFF_FFFF), value_t'(0),
               value_t'(-1), value_t'(1), value_t'(32'h0001_0000),
               value_t'(32'hFFFF_0000)};
    send_list(list_q);
    // duplicates
    list_q = '{value_t'(5), value_t'(5), value_t'(-3), value_t'(5), value_t'(-3)};
    send_list(list_q);
    // reverse order
    list_q = '{value_t'(32'h0006_0000), value_t'(32'h0005_0000), value_t'(32'h0004_0000),
               value_t'(32'h0003_0000), value_t'(32'h0002_0000), value_t'(32'h0001_0000)};
    send_list(list_q);
    list_q = '{value_t'(32'h8000_0000), value_t'(32'h8000_0000)};
    send_list(list_q);

    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 16; recv_idle_pct = 78; end
        1: begin send_idle_pct = 78; recv_idle_pct = 16; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      phase_goal = (phase + 1) * RANDOM_ITEMS / 3;
      if (phase == 0) begin
        // exactly full, full with the marked value dropped, well past full
        send_set(STORE_DEPTH, 1'b0);
        send_set(STORE_DEPTH + 1, 1'b0);
        send_set(STORE_DEPTH + 8, 1'b0);
        sent += 3 * STORE_DEPTH + 9;
      end
      if (phase == 2) begin
        // drain of a full set held back while the next set is offered
        send_set(STORE_DEPTH, 1'b1);
        sent += STORE_DEPTH;
      end
      while (sent < phase_goal) begin
        len = pick_length();
        send_set(len, 1'b0);
        sent += len;
      end
    end
    in_ch.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_GUARD) @(posedge clk);
    if (sb.errors == 0)
      $display("** ascending_value_sorter: PASSED **");
    else
      $display("** ascending_value_sorter: FAILED **");
    $finish;
  end

endmodule

/* ascending_value_sorter.f */
hdl/avs_pkg.sv
hdl/avs_in_if.sv
hdl/avs_out_if.sv
hdl/avs_cell.sv
hdl/ascending_value_sorter.sv
dv/tb_ascending_value_sorter.sv
